// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequence checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
package rrts_pkg;
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_ADD     = 3'd1,
      OP_SLEEP   = 3'd2,
      OP_BLOCK   = 3'd3,
      OP_UNBLOCK = 3'd4,
      OP_TERM    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      TS_FREE  = 3'd0,
      TS_RUN   = 3'd1,
      TS_READY = 3'd2,
      TS_SLEEP = 3'd3,
      TS_BLOCK = 3'd4
   } task_state_type;

   typedef enum logic [1:0] {
      CSR_QUANTUM = 2'd0,
      CSR_TICK    = 2'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      F_IDLE, F_START, F_WAKE_RD, F_WAKE, F_PUSH, F_PUSH_W, F_QUANT, F_SCHED,
      F_ACC, F_POP_RD, F_POP, F_CHK, F_POST, F_RM_RD, F_RM, F_LINK_RD, F_LINK,
      F_SW_RD, F_SW, F_ST_RD, F_ST, F_BLK, F_DONE
   } fsm_type;

   localparam logic [31:0] QUANTUM_RESET = 32'd5000000;
   localparam logic [31:0] TICK_RESET    = 32'd1000000;
endpackage

// ===== rtl/rrts_if.sv =====
`timescale 1ns / 1ps
interface rrts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [3:0]  task_req;
   logic [63:0] now_ns;
   logic [63:0] wake_at_ns;
   modport source (output valid, op, task_req, now_ns, wake_at_ns, input ready);
   modport sink (input valid, op, task_req, now_ns, wake_at_ns, output ready);
endinterface

interface rrts_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] current_task;
   logic       cpu_idle;
   logic       switched;
   logic [4:0] woken_count;
   logic       status;
   modport source (output valid, current_task, cpu_idle, switched, woken_count, status,
                   input ready);
   modport sink (input valid, current_task, cpu_idle, switched, woken_count, status,
                 output ready);
endinterface

// ===== rtl/round_robin_task_scheduler_top.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// req_ch   in   valid/ready        op, task_req, now_ns, wake_at_ns
// rsp_ch   out  valid/ready        current_task, cpu_idle, switched, woken_count, status
// csr      in   csr_we, no ready   csr_index, csr_wdata
// one transaction at a time: a sequencer walks the slot memory with one read per
// list entry walked (sorted sleep insert, terminate unlink) and writes back only
// the records it changes, including each sleeper woken
// reset is synchronous; slot records come out of reset through valid bits, no sweep
// a held result does not stop the next transaction from being accepted; the one
// after waits in the last state until the result register frees up
module round_robin_task_scheduler_top import rrts_pkg::*; #(
   parameter int MAX_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   rrts_req_if.sink    req_ch,
   rrts_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   typedef struct packed {
      logic [IW-1:0]  link;
      task_state_type st;
      logic [63:0]    wake;
      logic [63:0]    run;
   } rec_type;

   fsm_type fsm_ff, fsm_in, ret_ff, ret_in;
   logic [31:0] quantum_len_ff, tick_int_ff;
   logic [2:0]  op_ff, op_in;
   logic [IW-1:0] t_ff, t_in;
   logic [63:0] now_ff, now_in, wake_at_ff, wake_at_in;
   logic        req_ok_ff, req_ok_in;
   logic [IW-1:0] rhead_ff, rhead_in, rtail_ff, rtail_in, shead_ff, shead_in;
   logic [CW-1:0] rcount_ff, rcount_in, scount_ff, scount_in;
   logic [IW-1:0] running_ff, running_in;
   logic        idle_ff, idle_in;
   logic [31:0] quantum_ff, quantum_in;
   logic [63:0] dispatch_ff, dispatch_in, idle_since_ff, idle_since_in;
   logic [63:0] idle_total_ff, idle_total_in;
   logic [IW-1:0] push_ff, push_in, cur_ff, cur_in, prev_ff, prev_in, save_ff, save_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        has_prev_ff, has_prev_in, rm_ready_ff, rm_ready_in;
   logic        sw_ff, sw_in, bad_ff, bad_in;
   logic [4:0]  woken_ff, woken_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_task_ff, rsp_task_in;
   logic        rsp_idle_ff, rsp_idle_in, rsp_sw_ff, rsp_sw_in, rsp_bad_ff, rsp_bad_in;
   logic [4:0]  rsp_woken_ff, rsp_woken_in;

   logic          mem_we;
   logic [IW-1:0] mem_waddr, mem_raddr;
   rec_type       wr_rec, rd_rec, init_first, init_rest;
   logic [CW-1:0] list_count;

   assign init_first = '{link: '0, st: TS_RUN, wake: '0, run: '0};
   assign init_rest  = '{link: '0, st: TS_FREE, wake: '0, run: '0};

   rrts_slot_mem #(.DEPTH(1 << IW), .WIDTH($bits(rec_type))) u_mem (
      .clock(clock), .reset(reset), .we(mem_we), .waddr(mem_waddr), .wdata(wr_rec),
      .raddr(mem_raddr), .init_first(init_first), .init_rest(init_rest), .rdata(rd_rec)
   );

   assign req_ch.ready = (fsm_ff == F_IDLE);
   assign list_count = rm_ready_ff ? rcount_ff : scount_ff;

   always_comb begin
      fsm_in = fsm_ff; ret_in = ret_ff;
      op_in = op_ff; t_in = t_ff; now_in = now_ff; wake_at_in = wake_at_ff;
      req_ok_in = req_ok_ff;
      rhead_in = rhead_ff; rtail_in = rtail_ff; rcount_in = rcount_ff;
      shead_in = shead_ff; scount_in = scount_ff;
      running_in = running_ff; idle_in = idle_ff; quantum_in = quantum_ff;
      dispatch_in = dispatch_ff; idle_since_in = idle_since_ff;
      idle_total_in = idle_total_ff;
      push_in = push_ff; cur_in = cur_ff; prev_in = prev_ff; save_in = save_ff;
      idx_in = idx_ff; has_prev_in = has_prev_ff; rm_ready_in = rm_ready_ff;
      sw_in = sw_ff; bad_in = bad_ff; woken_in = woken_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_task_in = rsp_task_ff; rsp_idle_in = rsp_idle_ff; rsp_sw_in = rsp_sw_ff;
      rsp_woken_in = rsp_woken_ff; rsp_bad_in = rsp_bad_ff;
      mem_we = 1'b0; mem_waddr = '0; mem_raddr = '0; wr_rec = rd_rec;

      case (fsm_ff)
         F_IDLE: begin
            if (req_ch.valid) begin
               op_in = req_ch.op;
               t_in = IW'(req_ch.task_req);
               req_ok_in = ({28'd0, req_ch.task_req} < 32'(MAX_TASKS));
               now_in = req_ch.now_ns;
               wake_at_in = req_ch.wake_at_ns;
               sw_in = 1'b0; bad_in = 1'b0; woken_in = '0;
               fsm_in = F_START;
            end
         end
         F_START: begin
            case (op_ff)
               OP_TICK: fsm_in = F_WAKE_RD;
               OP_ADD, OP_UNBLOCK, OP_TERM: begin
                  mem_raddr = t_ff;
                  if (!req_ok_ff) begin
                     bad_in = 1'b1; fsm_in = F_DONE;
                  end else begin
                     fsm_in = F_CHK;
                  end
               end
               OP_SLEEP: begin
                  cur_in = shead_ff; idx_in = '0; has_prev_in = 1'b0;
                  if (idle_ff) begin
                     bad_in = 1'b1; fsm_in = F_DONE;
                  end else begin
                     fsm_in = F_SW_RD;
                  end
               end
               OP_BLOCK: begin
                  mem_raddr = running_ff;
                  if (idle_ff) begin
                     bad_in = 1'b1; fsm_in = F_DONE;
                  end else begin
                     fsm_in = F_BLK;
                  end
               end
               default: begin
                  bad_in = 1'b1; fsm_in = F_DONE;
               end
            endcase
         end
         F_WAKE_RD: begin
            mem_raddr = shead_ff;
            fsm_in = (scount_ff != '0) ? F_WAKE : F_QUANT;
         end
         F_WAKE: begin
            if (rd_rec.wake <= now_ff) begin
               mem_we = 1'b1; mem_waddr = shead_ff;
               wr_rec.link = '0; wr_rec.st = TS_READY;
               shead_in = rd_rec.link;
               scount_in = scount_ff - CW'(1);
               woken_in = woken_ff + 5'd1;
               push_in = shead_ff; ret_in = F_WAKE_RD; fsm_in = F_PUSH;
            end else begin
               fsm_in = F_QUANT;
            end
         end
         F_PUSH: begin
            mem_raddr = rtail_ff;
            if (rcount_ff == '0) begin
               rhead_in = push_ff; rtail_in = push_ff;
               rcount_in = rcount_ff + CW'(1);
               fsm_in = ret_ff;
            end else begin
               fsm_in = F_PUSH_W;
            end
         end
         F_PUSH_W: begin
            mem_we = 1'b1; mem_waddr = rtail_ff; wr_rec.link = push_ff;
            rtail_in = push_ff; rcount_in = rcount_ff + CW'(1);
            fsm_in = ret_ff;
         end
         F_QUANT: begin
            fsm_in = F_DONE;
            if (idle_ff) begin
               if (rcount_ff != '0) fsm_in = F_SCHED;
            end else if (quantum_ff != '0) begin
               if (quantum_ff <= tick_int_ff) fsm_in = F_SCHED;
               else quantum_in = quantum_ff - tick_int_ff;
            end
         end
         F_SCHED: begin
            mem_raddr = running_ff;
            if (idle_ff) begin
               idle_total_in = idle_total_ff + (now_ff - idle_since_ff);
               idle_since_in = now_ff;
               fsm_in = (rcount_ff != '0) ? F_POP_RD : F_DONE;
            end else begin
               fsm_in = F_ACC;
            end
         end
         F_ACC: begin
            mem_we = 1'b1; mem_waddr = running_ff;
            wr_rec.run = rd_rec.run + (now_ff - dispatch_ff);
            dispatch_in = now_ff;
            if (rcount_ff != '0) begin
               if (rd_rec.st == TS_RUN) begin
                  wr_rec.st = TS_READY; wr_rec.link = '0;
                  push_in = running_ff; ret_in = F_POP_RD; fsm_in = F_PUSH;
               end else begin
                  fsm_in = F_POP_RD;
               end
            end else begin
               if (rd_rec.st != TS_RUN) begin
                  idle_in = 1'b1; idle_since_in = now_ff; quantum_in = '0;
               end
               fsm_in = F_DONE;
            end
         end
         F_POP_RD: begin
            mem_raddr = rhead_ff;
            fsm_in = F_POP;
         end
         F_POP: begin
            mem_we = 1'b1; mem_waddr = rhead_ff; wr_rec.st = TS_RUN;
            rhead_in = rd_rec.link; rcount_in = rcount_ff - CW'(1);
            sw_in = idle_ff | (rhead_ff != running_ff);
            running_in = rhead_ff; idle_in = 1'b0;
            quantum_in = quantum_len_ff; dispatch_in = now_ff;
            fsm_in = F_DONE;
         end
         F_CHK: begin
            mem_waddr = t_ff;
            fsm_in = F_DONE;
            case (op_ff)
               OP_ADD, OP_UNBLOCK: begin
                  if (rd_rec.st != ((op_ff == OP_ADD) ? TS_FREE : TS_BLOCK)) begin
                     bad_in = 1'b1;
                  end else begin
                     mem_we = 1'b1;
                     wr_rec.link = '0; wr_rec.st = TS_READY;
                     if (op_ff == OP_ADD) wr_rec.run = '0;
                     push_in = t_ff; ret_in = F_POST; fsm_in = F_PUSH;
                  end
               end
               default: begin
                  if (rd_rec.st == TS_FREE) begin
                     bad_in = 1'b1;
                  end else begin
                     mem_we = 1'b1; wr_rec.st = TS_FREE;
                     idx_in = '0; ret_in = F_DONE;
                     if (rd_rec.st == TS_READY) begin
                        rm_ready_in = 1'b1; cur_in = rhead_ff; fsm_in = F_RM_RD;
                     end else if (rd_rec.st == TS_SLEEP) begin
                        rm_ready_in = 1'b0; cur_in = shead_ff; fsm_in = F_RM_RD;
                     end else if (rd_rec.st == TS_RUN && !idle_ff && t_ff == running_ff) begin
                        fsm_in = F_SCHED;
                     end
                  end
               end
            endcase
         end
         F_POST: fsm_in = idle_ff ? F_SCHED : F_DONE;
         F_RM_RD: begin
            mem_raddr = cur_ff;
            fsm_in = (idx_ff < list_count) ? F_RM : F_DONE;
         end
         F_RM: begin
            if (cur_ff == t_ff) begin
               if (rm_ready_ff) begin
                  rcount_in = rcount_ff - CW'(1);
                  if ((idx_ff + CW'(1)) == rcount_ff) rtail_in = prev_ff;
               end else begin
                  scount_in = scount_ff - CW'(1);
               end
               if (idx_ff == '0) begin
                  if (rm_ready_ff) rhead_in = rd_rec.link;
                  else shead_in = rd_rec.link;
                  fsm_in = F_DONE;
               end else begin
                  save_in = rd_rec.link; fsm_in = F_LINK_RD;
               end
            end else begin
               prev_in = cur_ff; cur_in = rd_rec.link;
               idx_in = idx_ff + CW'(1); fsm_in = F_RM_RD;
            end
         end
         F_LINK_RD: begin
            mem_raddr = prev_ff;
            fsm_in = F_LINK;
         end
         F_LINK: begin
            mem_we = 1'b1; mem_waddr = prev_ff; wr_rec.link = save_ff;
            fsm_in = ret_ff;
         end
         F_SW_RD: begin
            mem_raddr = cur_ff;
            fsm_in = (idx_ff < scount_ff) ? F_SW : F_ST_RD;
         end
         F_SW: begin
            if (rd_rec.wake <= wake_at_ff) begin
               prev_in = cur_ff; save_in = rd_rec.link; has_prev_in = 1'b1;
               cur_in = rd_rec.link; idx_in = idx_ff + CW'(1); fsm_in = F_SW_RD;
            end else begin
               fsm_in = F_ST_RD;
            end
         end
         F_ST_RD: begin
            mem_raddr = running_ff;
            fsm_in = F_ST;
         end
         F_ST: begin
            mem_we = 1'b1; mem_waddr = running_ff;
            wr_rec.link = has_prev_ff ? save_ff : shead_ff;
            wr_rec.st = TS_SLEEP; wr_rec.wake = wake_at_ff;
            scount_in = scount_ff + CW'(1);
            if (has_prev_ff) begin
               save_in = running_ff; ret_in = F_SCHED; fsm_in = F_LINK_RD;
            end else begin
               shead_in = running_ff; fsm_in = F_SCHED;
            end
         end
         F_BLK: begin
            mem_we = 1'b1; mem_waddr = running_ff; wr_rec.st = TS_BLOCK;
            fsm_in = F_SCHED;
         end
         F_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_task_in = idle_ff ? 4'd0 : 4'(running_ff);
               rsp_idle_in = idle_ff; rsp_sw_in = sw_ff;
               rsp_woken_in = woken_ff; rsp_bad_in = bad_ff;
               fsm_in = F_IDLE;
            end
         end
         default: fsm_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= F_IDLE; ret_ff <= F_DONE;
         quantum_len_ff <= QUANTUM_RESET; tick_int_ff <= TICK_RESET;
         rhead_ff <= '0; rtail_ff <= '0; rcount_ff <= '0;
         shead_ff <= '0; scount_ff <= '0;
         running_ff <= '0; idle_ff <= 1'b0; quantum_ff <= '0;
         dispatch_ff <= '0; idle_since_ff <= '0; idle_total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in; ret_ff <= ret_in;
         if (csr_we) begin
            if (csr_index == CSR_QUANTUM[0]) quantum_len_ff <= csr_wdata;
            else tick_int_ff <= csr_wdata;
         end
         rhead_ff <= rhead_in; rtail_ff <= rtail_in; rcount_ff <= rcount_in;
         shead_ff <= shead_in; scount_ff <= scount_in;
         running_ff <= running_in; idle_ff <= idle_in; quantum_ff <= quantum_in;
         dispatch_ff <= dispatch_in; idle_since_ff <= idle_since_in;
         idle_total_ff <= idle_total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; t_ff <= t_in; now_ff <= now_in; wake_at_ff <= wake_at_in;
      req_ok_ff <= req_ok_in;
      push_ff <= push_in; cur_ff <= cur_in; prev_ff <= prev_in; save_ff <= save_in;
      idx_ff <= idx_in; has_prev_ff <= has_prev_in; rm_ready_ff <= rm_ready_in;
      sw_ff <= sw_in; bad_ff <= bad_in; woken_ff <= woken_in;
      rsp_task_ff <= rsp_task_in; rsp_idle_ff <= rsp_idle_in; rsp_sw_ff <= rsp_sw_in;
      rsp_woken_ff <= rsp_woken_in; rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.current_task = rsp_task_ff;
   assign rsp_ch.cpu_idle     = rsp_idle_ff;
   assign rsp_ch.switched     = rsp_sw_ff;
   assign rsp_ch.woken_count  = rsp_woken_ff;
   assign rsp_ch.status       = rsp_bad_ff;
endmodule

// ===== rtl/rrts_slot_mem.sv =====
`timescale 1ns / 1ps
module rrts_slot_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   input  logic [WIDTH-1:0]         init_first,
   input  logic [WIDTH-1:0]         init_rest,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_ff;
   logic             rd_valid_ff;
   logic             rd_first_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   // entries never written read as their reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[raddr];
         rd_first_ff <= (raddr == '0);
      end
   end

   assign rdata = rd_valid_ff ? rd_ff : (rd_first_ff ? init_first : init_rest);
endmodule

// ===== rtl/rrts_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrts_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] current_task,
   input logic       cpu_idle,
   input logic       switched,
   input logic [4:0] woken_count,
   input logic       status
);
   logic [11:0] rsp_word;

   assign rsp_word = {current_task, cpu_idle, switched, woken_count, status};

   // a stalled result holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
             rsp_valid && $stable(rsp_word), "result changed while stalled")
   `CHK_IMPL(a_idle_task, clock, reset, rsp_valid && cpu_idle, current_task == 4'd0,
             "idle cpu reports a task")
   `CHK_IMPL(a_switch_run, clock, reset, rsp_valid && switched, !cpu_idle && !status,
             "switch without running task")
   // only a tick wakes sleepers and a tick is never rejected
   `CHK_IMPL(a_woken_ok, clock, reset, rsp_valid && woken_count != 5'd0, !status,
             "rejected transaction woke tasks")
endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .current_task(rsp_ch.current_task), .cpu_idle(rsp_ch.cpu_idle),
   .switched(rsp_ch.switched), .woken_count(rsp_ch.woken_count), .status(rsp_ch.status)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import rrts_pkg::*;

   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE = 60;
   localparam logic [2:0] OP_BAD6 = 3'd6;
   localparam logic [2:0] OP_BAD7 = 3'd7;
   localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [3:0] cur;
      logic       idle;
      logic       sw;
      logic [4:0] woken;
      logic       st;
   } sched_result_t;

   typedef struct packed {
      logic [2:0]    op;
      logic [3:0]    tsk;
      logic [63:0]   now;
      logic [63:0]   wake;
      logic          typed;
      sched_result_t res;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;

   rrts_req_if req_ch ();
   rrts_rsp_if rsp_ch ();

   round_robin_task_scheduler_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // scheduler mirror
   task_state_type slot_state [NSLOT];
   logic [3:0]  slot_link [NSLOT];
   logic [63:0] slot_wake [NSLOT];
   logic [63:0] slot_run [NSLOT];
   logic [3:0]  rdy_head, rdy_tail, slp_head, cur_task;
   int          rdy_cnt, slp_cnt;
   logic        cpu_off;
   logic [31:0] quantum_left, quantum_len, tick_len;
   logic [63:0] dispatch_mark, idle_mark, idle_sum;

   sched_result_t sched_expected [$];
   int errors = 0, items_sent = 0, results_seen = 0, switches_seen = 0, wakes_seen = 0;
   int cycles = 0;
   logic [63:0] clock_ns = 0, last_wake = 0;

   function automatic void mirror_reset();
      for (int i = 0; i < NSLOT; i++) begin
         slot_state[i] = TS_FREE;
         slot_link[i] = '0;
         slot_wake[i] = '0;
         slot_run[i] = '0;
      end
      slot_state[0] = TS_RUN;
      rdy_head = 0; rdy_tail = 0; rdy_cnt = 0;
      slp_head = 0; slp_cnt = 0;
      cur_task = 0; cpu_off = 1'b0; quantum_left = 0;
      dispatch_mark = 0; idle_mark = 0; idle_sum = 0;
      quantum_len = QUANTUM_RESET;
      tick_len = TICK_RESET;
   endfunction

   function automatic void ready_append(logic [3:0] t);
      slot_link[t] = 0;
      if (rdy_cnt == 0) begin
         rdy_head = t;
      end else begin
         slot_link[rdy_tail] = t;
      end
      rdy_tail = t;
      rdy_cnt++;
   endfunction

   function automatic logic [3:0] ready_take();
      logic [3:0] t;
      t = rdy_head;
      rdy_head = slot_link[t];
      rdy_cnt--;
      return t;
   endfunction

   function automatic void unlink_slot(logic [3:0] t, bit from_ready);
      logic [3:0] cur, prev;
      int n;
      cur = from_ready ? rdy_head : slp_head;
      prev = 0;
      n = from_ready ? rdy_cnt : slp_cnt;
      for (int i = 0; i < n; i++) begin
         if (cur == t) begin
            if (i == 0) begin
               if (from_ready) rdy_head = slot_link[cur];
               else slp_head = slot_link[cur];
            end else begin
               slot_link[prev] = slot_link[cur];
            end
            if (from_ready) begin
               if (i + 1 == n) rdy_tail = prev;
               rdy_cnt--;
            end else begin
               slp_cnt--;
            end
            return;
         end
         prev = cur;
         cur = slot_link[cur];
      end
   endfunction

   function automatic bit reschedule(logic [63:0] now);
      logic [3:0] prev, nxt;
      bit was_off;
      if (cpu_off) begin
         idle_sum += now - idle_mark;
         idle_mark = now;
      end else begin
         slot_run[cur_task] += now - dispatch_mark;
         dispatch_mark = now;
      end
      if (rdy_cnt > 0) begin
         prev = cur_task;
         was_off = cpu_off;
         if (!cpu_off && slot_state[prev] == TS_RUN) begin
            slot_state[prev] = TS_READY;
            ready_append(prev);
         end
         nxt = ready_take();
         slot_state[nxt] = TS_RUN;
         cur_task = nxt;
         cpu_off = 1'b0;
         quantum_left = quantum_len;
         dispatch_mark = now;
         return was_off || nxt != prev;
      end
      if (!cpu_off && slot_state[cur_task] != TS_RUN) begin
         cpu_off = 1'b1;
         idle_mark = now;
         quantum_left = 0;
      end
      return 1'b0;
   endfunction

   function automatic sched_result_t predict_schedule(logic [2:0] op, logic [3:0] t,
                                                      logic [63:0] now, logic [63:0] wake);
      sched_result_t r;
      bit sw, bad;
      int woken;
      logic [3:0] s, cur, prev;
      bit has_prev;
      task_state_type old;
      sw = 0; bad = 0; woken = 0;
      case (op)
         OP_TICK: begin
            while (slp_cnt > 0 && slot_wake[slp_head] <= now) begin
               s = slp_head;
               slp_head = slot_link[s];
               slp_cnt--;
               slot_state[s] = TS_READY;
               ready_append(s);
               woken++;
            end
            if (cpu_off) begin
               if (rdy_cnt > 0) sw = reschedule(now);
            end else if (quantum_left != 0) begin
               if (quantum_left <= tick_len) sw = reschedule(now);
               else quantum_left -= tick_len;
            end
         end
         OP_ADD: begin
            if (slot_state[t] != TS_FREE) begin
               bad = 1;
            end else begin
               slot_state[t] = TS_READY;
               slot_run[t] = 0;
               ready_append(t);
               if (cpu_off) sw = reschedule(now);
            end
         end
         OP_SLEEP: begin
            if (cpu_off) begin
               bad = 1;
            end else begin
               s = cur_task;
               slot_wake[s] = wake;
               slot_state[s] = TS_SLEEP;
               cur = slp_head;
               prev = 0;
               has_prev = 0;
               for (int i = 0; i < slp_cnt && slot_wake[cur] <= wake; i++) begin
                  prev = cur;
                  has_prev = 1;
                  cur = slot_link[cur];
               end
               if (!has_prev) begin
                  slot_link[s] = slp_head;
                  slp_head = s;
               end else begin
                  slot_link[s] = slot_link[prev];
                  slot_link[prev] = s;
               end
               slp_cnt++;
               sw = reschedule(now);
            end
         end
         OP_BLOCK: begin
            if (cpu_off) begin
               bad = 1;
            end else begin
               slot_state[cur_task] = TS_BLOCK;
               sw = reschedule(now);
            end
         end
         OP_UNBLOCK: begin
            if (slot_state[t] != TS_BLOCK) begin
               bad = 1;
            end else begin
               slot_state[t] = TS_READY;
               ready_append(t);
               if (cpu_off) sw = reschedule(now);
            end
         end
         OP_TERM: begin
            if (slot_state[t] == TS_FREE) begin
               bad = 1;
            end else begin
               old = slot_state[t];
               slot_state[t] = TS_FREE;
               if (old == TS_READY) unlink_slot(t, 1'b1);
               else if (old == TS_SLEEP) unlink_slot(t, 1'b0);
               else if (old == TS_RUN && !cpu_off && t == cur_task) sw = reschedule(now);
            end
         end
         default: bad = 1;
      endcase
      r.cur = cpu_off ? 4'd0 : cur_task;
      r.idle = cpu_off;
      r.sw = sw;
      r.woken = 5'(woken);
      r.st = bad;
      return r;
   endfunction

   // one transaction on the request channel, then a random gap
   task automatic send_item(logic [2:0] op, logic [3:0] t, logic [63:0] now,
                            logic [63:0] wake, bit typed, sched_result_t typed_res);
      sched_result_t r;
      int gap, pick;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.task_req <= t;
      req_ch.now_ns <= now;
      req_ch.wake_at_ns <= wake;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      r = predict_schedule(op, t, now, wake);
      sched_expected.push_back(typed ? typed_res : r);
      items_sent++;
      pick = $urandom_range(0, 99);
      gap = pick < 65 ? 0 : pick < 93 ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      while (sched_expected.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx[0];
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_QUANTUM) quantum_len = val;
      else tick_len = val;
   endtask

   function automatic logic [3:0] pick_slot(task_state_type want);
      logic [3:0] list [$];
      for (int i = 0; i < NSLOT; i++)
         if (slot_state[i] == want) list.push_back(4'(i));
      if (list.size() == 0 || $urandom_range(0, 9) < 2) return 4'($urandom_range(0, 15));
      return list[$urandom_range(0, list.size() - 1)];
   endfunction

   task automatic random_phase(int n);
      logic [2:0] op;
      logic [3:0] t;
      logic [63:0] wake;
      int w;
      for (int k = 0; k < n; k++) begin
         w = $urandom_range(0, 99);
         if ($urandom_range(0, 49) == 0) clock_ns = {$urandom, $urandom};
         else clock_ns += $urandom_range(0, 3000000);
         t = 4'($urandom_range(0, 15));
         if (w < 36) begin
            op = OP_TICK;
         end else if (w < 52) begin
            op = OP_ADD;
            t = pick_slot(TS_FREE);
         end else if (w < 65) begin
            op = OP_SLEEP;
         end else if (w < 73) begin
            op = OP_BLOCK;
         end else if (w < 86) begin
            op = OP_UNBLOCK;
            t = pick_slot(TS_BLOCK);
         end else if (w < 97) begin
            op = OP_TERM;
            t = 4'($urandom_range(0, 15));
         end else begin
            op = $urandom_range(0, 1) ? OP_BAD6 : OP_BAD7;
         end
         w = $urandom_range(0, 99);
         if (w < 12) wake = last_wake;
         else if (w < 17) wake = {$urandom, $urandom};
         else if (w < 20) wake = 0;
         else wake = clock_ns + $urandom_range(0, 20000000);
         if (op == OP_SLEEP) last_wake = wake;
         send_item(op, t, clock_ns, wake, 1'b0, '0);
      end
      req_ch.valid <= 1'b0;
   endtask

   dir_row_t dir_rows [20] = '{
      '{OP_TICK,    4'd0,  64'd0,   64'd0,   1'b1, '{4'd0, 1'b0, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,     4'd0,  64'd5,   64'd0,   1'b1, '{4'd0, 1'b0, 1'b0, 5'd0, 1'b1}},
      '{OP_BAD6,    4'd0,  64'd6,   64'd0,   1'b1, '{4'd0, 1'b0, 1'b0, 5'd0, 1'b1}},
      '{OP_BAD7,    4'd15, 64'd7,   T_MAX,   1'b1, '{4'd0, 1'b0, 1'b0, 5'd0, 1'b1}},
      '{OP_UNBLOCK, 4'd3,  64'd8,   64'd0,   1'b1, '{4'd0, 1'b0, 1'b0, 5'd0, 1'b1}},
      '{OP_TERM,    4'd9,  64'd9,   64'd0,   1'b1, '{4'd0, 1'b0, 1'b0, 5'd0, 1'b1}},
      '{OP_ADD,     4'd15, 64'd10,  64'd0,   1'b0, '0},
      '{OP_ADD,     4'd1,  64'd11,  64'd0,   1'b0, '0},
      '{OP_SLEEP,   4'd0,  64'd12,  64'd100, 1'b0, '0},
      '{OP_SLEEP,   4'd0,  64'd13,  64'd100, 1'b0, '0},
      '{OP_BLOCK,   4'd0,  64'd14,  64'd0,   1'b1, '{4'd0, 1'b1, 1'b0, 5'd0, 1'b0}},
      '{OP_SLEEP,   4'd0,  64'd15,  64'd0,   1'b1, '{4'd0, 1'b1, 1'b0, 5'd0, 1'b1}},
      '{OP_TICK,    4'd0,  64'd100, 64'd0,   1'b0, '0},
      '{OP_UNBLOCK, 4'd1,  64'd101, 64'd0,   1'b0, '0},
      '{OP_TERM,    4'd15, 64'd102, 64'd0,   1'b0, '0},
      '{OP_SLEEP,   4'd0,  64'd103, T_MAX,   1'b0, '0},
      '{OP_TICK,    4'd0,  T_MAX,   64'd0,   1'b0, '0},
      '{OP_TERM,    4'd1,  64'd104, 64'd0,   1'b0, '0},
      '{OP_ADD,     4'd10, 64'd0,   64'd0,   1'b0, '0},
      '{OP_TERM,    4'd0,  64'd105, 64'd0,   1'b0, '0}
   };

   // result side: random stalls, with calm stretches
   int stall_left = 0;
   bit calm = 1'b0;
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) calm <= ~calm;
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sched_result_t got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.current_task, rsp_ch.cpu_idle, rsp_ch.switched,
                 rsp_ch.woken_count, rsp_ch.status};
         results_seen++;
         if (got.sw) switches_seen++;
         wakes_seen += got.woken;
         if (sched_expected.size() == 0) begin
            $display("%0t: unexpected transaction on result channel: %p", $time, got);
            errors++;
         end else begin
            want = sched_expected.pop_front();
            if (got.cur !== want.cur)
               $display("%0t: current_task expected %0d actual %0d", $time, want.cur, got.cur);
            if (got.idle !== want.idle)
               $display("%0t: cpu_idle expected %0d actual %0d", $time, want.idle, got.idle);
            if (got.sw !== want.sw)
               $display("%0t: switched expected %0d actual %0d", $time, want.sw, got.sw);
            if (got.woken !== want.woken)
               $display("%0t: woken_count expected %0d actual %0d", $time, want.woken,
                        got.woken);
            if (got.st !== want.st)
               $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            if (got !== want) errors++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time, sched_expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = OP_TICK;
      req_ch.task_req = '0;
      req_ch.now_ns = '0;
      req_ch.wake_at_ns = '0;
      mirror_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].tsk, dir_rows[i].now, dir_rows[i].wake,
                   dir_rows[i].typed, dir_rows[i].res);
      req_ch.valid <= 1'b0;
      clock_ns = 1000;
      random_phase(250);
      drain_and_settle();
      // every tick ends the slice
      write_reg(CSR_QUANTUM, 32'd1);
      write_reg(CSR_TICK, 32'hFFFF_FFFF);
      random_phase(150);
      drain_and_settle();
      // slice practically never ends
      write_reg(CSR_QUANTUM, 32'hFFFF_FFFF);
      write_reg(CSR_TICK, 32'd1);
      random_phase(150);
      drain_and_settle();
      write_reg(CSR_QUANTUM, 32'd3000000);
      write_reg(CSR_TICK, 32'd1000000);
      random_phase(150);
      drain_and_settle();
      $display("sent %0d scheduler requests over four quantum/tick settings", items_sent);
      $display("checked %0d responses, %0d task switches, %0d sleepers woken",
               results_seen, switches_seen, wakes_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
